// File: src/ppt_pkg.sv
// Shared types and constants of the projected polygon point test.
`default_nettype none
package ppt_pkg;

  // Field and datapath widths.
  localparam int CoordW = 24;   // Q16.8 coordinate
  localparam int FocW   = 16;   // configuration register width
  localparam int NumW   = 48;   // projection numerator v*F*256
  localparam int DenW   = 26;   // projection denominator z + F*256
  localparam int DvW    = 25;   // magnitude of the denominator
  localparam int PW     = 50;   // projected coordinate with centre added
  localparam int DW     = 51;   // difference of two projected values
  localparam int MW     = 52;   // multiplier operand padded to whole digits
  localparam int PrW    = 104;  // signed product of two differences
  localparam int InW    = 8 * CoordW;
  localparam int OutW   = 16;
  localparam int CntOutW = 11;
  localparam int CfgIdxW = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegFocal   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterX = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCenterY = 2'd2;

  localparam logic [FocW-1:0] FocalReset   = 16'd30;
  localparam logic [FocW-1:0] CenterXReset = 16'd160;
  localparam logic [FocW-1:0] CenterYReset = 16'd120;

  // Projected coordinate order.
  localparam logic [1:0] AxisX1 = 2'd0;
  localparam logic [1:0] AxisY1 = 2'd1;
  localparam logic [1:0] AxisX2 = 2'd2;
  localparam logic [1:0] AxisY2 = 2'd3;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       div_start;
    logic       proj_store;
    logic       mul_start;
    logic       mul_sel;
    logic       prod_store;
    logic       count_upd;
    logic       emit;
    logic [1:0] axis;
  } ppt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic straddle;
    logic last;
  } ppt_stat_t;

endpackage
`default_nettype wire

// File: src/projected_polygon_point_test.sv
// Top level of the projected polygon point test.
`default_nettype none
// Each input word is one polygon edge (two 3D endpoints) plus a screen test
// point; both endpoints are perspective-projected and the edge is tested
// against a ray running right from the test point. On the word marked with
// tlast the block returns the crossing count, its parity and a degenerate
// flag, then clears its count. Each edge runs four 24-step projections on
// the shared radix-4 divider and, only when it straddles the test y, two
// 13-step multiplies on the shared radix-16 multiplier. A result waits in
// an output register, and the next edge is accepted meanwhile, though an
// edge marked with tlast does not finish until the result is taken.
module projected_polygon_point_test import ppt_pkg::*; #(
  parameter int MAX_EDGES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // tdata from bit 0: test_x, test_y, start_x, start_y, start_z,
  // end_x, end_y, end_z (24 bits each).
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [InW-1:0]     s_axis_tdata,
  input  wire logic               s_axis_tlast,
  // tdata from bit 0: crossings (11 bits), inside_res, degenerate, zero fill.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [OutW-1:0]    m_axis_tdata,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [FocW-1:0]    cfg_data_i
);

  ppt_cmd_t  cmd;
  ppt_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ppt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ppt_datapath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// File: src/ppt_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
`default_nettype none
module ppt_div import ppt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] dividend_i,
  input  wire logic [DvW-1:0]  divisor_i,
  output logic      [NumW-1:0] quot_o,
  output logic                 done_o
);

  localparam int Steps = NumW / 2;
  localparam int CntW  = $clog2(Steps + 1);

  logic [NumW-1:0] quo_q;
  logic [DvW-1:0]  rem_q;
  logic [DvW-1:0]  dv_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DvW:0]    st1;
  logic [DvW:0]    st2;

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [DvW:0] div_step(input logic [DvW-1:0] rem,
                                            input logic bit_in,
                                            input logic [DvW-1:0] dv);
    logic [DvW:0] r;
    logic [DvW:0] s;
    r = {rem, bit_in};
    s = r - {1'b0, dv};
    if (r >= {1'b0, dv}) begin
      div_step = {1'b1, s[DvW-1:0]};
    end else begin
      div_step = {1'b0, r[DvW-1:0]};
    end
  endfunction

  assign st1 = div_step(rem_q, quo_q[NumW-1], dv_q);
  assign st2 = div_step(st1[DvW-1:0], quo_q[NumW-2], dv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NumW-3:0], st1[DvW], st2[DvW]};
      rem_q <= st2[DvW-1:0];
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: src/ppt_mul.sv
// Iterative unsigned multiplier, one 4-bit digit of the second operand per cycle.
`default_nettype none
module ppt_mul import ppt_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DW-1:0]  a_i,
  input  wire logic [MW-1:0]  b_i,
  output logic      [PrW-1:0] prod_o,
  output logic                done_o
);

  localparam int Steps = MW / 4;
  localparam int CntW  = $clog2(Steps + 1);

  logic [DW-1:0]   a_q;
  logic [MW-1:0]   b_q;
  logic [PrW-1:0]  acc_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DW+3:0]   pp;

  // The most significant digit goes first, so the sum shifts left.
  assign pp = a_q * b_q[MW-1 -: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[PrW-5:0], 4'h0} + {{(PrW-DW-4){1'b0}}, pp};
      b_q   <= {b_q[MW-5:0], 4'h0};
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: src/ppt_datapath.sv
// Datapath: configuration registers, projection, edge test and crossing count.
`default_nettype none
module ppt_datapath import ppt_pkg::*; #(
  parameter int MAX_EDGES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [InW-1:0]     in_data_i,
  input  wire logic               in_last_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [FocW-1:0]    cfg_data_i,
  input  wire ppt_cmd_t           cmd_i,
  output ppt_stat_t               stat_o,
  output logic      [OutW-1:0]    out_data_o
);

  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_EDGES);
  localparam logic signed [PW-1:0] SatMag = PW'(64'h0000_FFFF_FFFF_FFFF);

  logic [FocW-1:0] focal_q, cx_q, cy_q;
  logic signed [CoordW-1:0] tx_q, ty_q, sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
  logic last_q;

  logic signed [CoordW-1:0] v_sel, z_sel;
  logic [FocW-1:0]          c_sel;
  logic signed [CoordW+FocW:0] vf;
  logic signed [NumW-1:0]   num_q;
  logic signed [DenW-1:0]   den_q;
  logic [NumW-1:0]          num_mag;
  logic [DenW-1:0]          den_abs;
  logic [NumW-1:0]          quot;
  logic                     div_done;
  logic                     den_zero;
  logic signed [PW-1:0]     q_ext, q_s, p_new;
  logic signed [PW-1:0]     p_q [4];

  logic signed [DW-1:0] tx_e, ty_e, x1_e, y1_e, x2_e, y2_e;
  logic signed [DW-1:0] da, db, dc, dd, opx, opy;
  logic [DW-1:0]        opx_mag, opy_mag;
  logic                 prod_neg;
  logic [PrW-1:0]       prod;
  logic signed [PrW-1:0] prod_s, prod1_q;
  logic                 mul_done;
  logic                 hit;

  logic [CW-1:0]         cnt_q;
  logic                  deg_q;
  logic [CW+CntOutW-1:0] cnt_ext;
  logic [OutW-1:0]       out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= FocalReset;
      cx_q    <= CenterXReset;
      cy_q    <= CenterYReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFocal:   focal_q <= cfg_data_i;
        RegCenterX: cx_q    <= cfg_data_i;
        RegCenterY: cy_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q   <= in_data_i[0*CoordW +: CoordW];
      ty_q   <= in_data_i[1*CoordW +: CoordW];
      sx_q   <= in_data_i[2*CoordW +: CoordW];
      sy_q   <= in_data_i[3*CoordW +: CoordW];
      sz_q   <= in_data_i[4*CoordW +: CoordW];
      ex_q   <= in_data_i[5*CoordW +: CoordW];
      ey_q   <= in_data_i[6*CoordW +: CoordW];
      ez_q   <= in_data_i[7*CoordW +: CoordW];
      last_q <= in_last_i;
    end
  end

  always_comb begin
    case (cmd_i.axis)
      AxisX1: begin
        v_sel = sx_q; z_sel = sz_q; c_sel = cx_q;
      end
      AxisY1: begin
        v_sel = sy_q; z_sel = sz_q; c_sel = cy_q;
      end
      AxisX2: begin
        v_sel = ex_q; z_sel = ez_q; c_sel = cx_q;
      end
      default: begin
        v_sel = ey_q; z_sel = ez_q; c_sel = cy_q;
      end
    endcase
  end

  assign vf = v_sel * $signed({1'b0, focal_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      num_q <= {vf[NumW-9:0], 8'h00};
      den_q <= {{(DenW-CoordW){z_sel[CoordW-1]}}, z_sel}
             + {{(DenW-FocW-8){1'b0}}, focal_q, 8'h00};
    end
  end

  assign num_mag = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
  assign den_abs = den_q[DenW-1] ? DenW'(-den_q) : DenW'(den_q);
  assign den_zero = (den_q == '0);

  ppt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_mag),
    .divisor_i  (den_abs[DvW-1:0]),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // Truncation toward zero: divide magnitudes, then apply the sign.
  always_comb begin
    q_ext = $signed({{(PW-NumW){1'b0}}, quot});
    if (den_zero) begin
      if (num_q == '0) begin
        q_s = '0;
      end else if (num_q[NumW-1]) begin
        q_s = -SatMag;
      end else begin
        q_s = SatMag;
      end
    end else if (num_q[NumW-1] ^ den_q[DenW-1]) begin
      q_s = -q_ext;
    end else begin
      q_s = q_ext;
    end
    p_new = q_s + $signed({{(PW-FocW-8){1'b0}}, c_sel, 8'h00});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.proj_store) begin
      p_q[cmd_i.axis] <= p_new;
    end
  end

  assign tx_e = {{(DW-CoordW){tx_q[CoordW-1]}}, tx_q};
  assign ty_e = {{(DW-CoordW){ty_q[CoordW-1]}}, ty_q};
  assign x1_e = {p_q[0][PW-1], p_q[0]};
  assign y1_e = {p_q[1][PW-1], p_q[1]};
  assign x2_e = {p_q[2][PW-1], p_q[2]};
  assign y2_e = {p_q[3][PW-1], p_q[3]};

  assign da = tx_e - x1_e;
  assign db = y2_e - y1_e;
  assign dc = ty_e - y1_e;
  assign dd = x2_e - x1_e;

  assign stat_o.straddle = (ty_e < y1_e) != (ty_e < y2_e);

  // First pass forms (tx - x1) * dy, second pass (ty - y1) * dx.
  assign opx      = cmd_i.mul_sel ? dc : da;
  assign opy      = cmd_i.mul_sel ? dd : db;
  assign opx_mag  = opx[DW-1] ? DW'(-opx) : DW'(opx);
  assign opy_mag  = opy[DW-1] ? DW'(-opy) : DW'(opy);
  assign prod_neg = opx[DW-1] ^ opy[DW-1];

  ppt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (opx_mag),
    .b_i     ({1'b0, opy_mag}),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  assign prod_s = prod_neg ? -$signed(prod) : $signed(prod);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_store) begin
      prod1_q <= prod_s;
    end
  end

  // A negative dy flips the sense of the comparison.
  assign hit = db[DW-1] ? (prod1_q > prod_s) : (prod1_q < prod_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      deg_q <= 1'b0;
    end else if (cmd_i.emit) begin
      cnt_q <= '0;
      deg_q <= 1'b0;
    end else begin
      if (cmd_i.count_upd && hit && (cnt_q < MaxCnt)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.proj_store && den_zero) begin
        deg_q <= 1'b1;
      end
    end
  end

  assign cnt_ext = {{CntOutW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= {{(OutW-CntOutW-2){1'b0}}, deg_q, cnt_q[0], cnt_ext[CntOutW-1:0]};
    end
  end

  assign out_data_o      = out_q;
  assign stat_o.div_done = div_done;
  assign stat_o.mul_done = mul_done;
  assign stat_o.last     = last_q;

endmodule
`default_nettype wire

// File: src/ppt_ctrl.sv
// Controller: sequences projection, edge test and result delivery per edge.
`default_nettype none
module ppt_ctrl import ppt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire ppt_stat_t stat_i,
  output ppt_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StPrep,
    StDivGo,
    StDivWait,
    StCheck,
    StMul0Go,
    StMul0Wait,
    StMul1Go,
    StMul1Wait,
    StFinish
  } state_e;

  state_e     state_q;
  logic [1:0] axis_q;
  logic       out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.axis    = axis_q;
    cmd_o.mul_sel = (state_q == StMul1Go) || (state_q == StMul1Wait);
    case (state_q)
      StIdle:     cmd_o.load       = in_valid_i;
      StPrep:     cmd_o.prep       = 1'b1;
      StDivGo:    cmd_o.div_start  = 1'b1;
      StDivWait:  cmd_o.proj_store = stat_i.div_done;
      StMul0Go:   cmd_o.mul_start  = 1'b1;
      StMul0Wait: cmd_o.prod_store = stat_i.mul_done;
      StMul1Go:   cmd_o.mul_start  = 1'b1;
      StMul1Wait: cmd_o.count_upd  = stat_i.mul_done;
      StFinish:   cmd_o.emit       = stat_i.last && !out_valid_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= AxisX1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            axis_q  <= AxisX1;
            state_q <= StPrep;
          end
        end
        StPrep:  state_q <= StDivGo;
        StDivGo: state_q <= StDivWait;
        StDivWait: begin
          if (stat_i.div_done) begin
            if (axis_q == AxisY2) begin
              state_q <= StCheck;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= StPrep;
            end
          end
        end
        StCheck: state_q <= stat_i.straddle ? StMul0Go : StFinish;
        StMul0Go: state_q <= StMul0Wait;
        StMul0Wait: begin
          if (stat_i.mul_done) begin
            state_q <= StMul1Go;
          end
        end
        StMul1Go: state_q <= StMul1Wait;
        StMul1Wait: begin
          if (stat_i.mul_done) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (!stat_i.last || !out_valid_q) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: tb/projected_polygon_point_test_tb.sv
// Self-checking testbench of the projected polygon point test.
`timescale 1ns / 100ps
module projected_polygon_point_test_tb;
  import ppt_pkg::*;

  localparam int MaxEdges = 1024;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam longint SatMag = 64'sd281474976710655;

  typedef struct {
    logic signed [CoordW-1:0] tx, ty, sx, sy, sz, ex, ey, ez;
    logic last;
  } poly_edge_t;

  // Packed from the top bit down, so crossings lands in the low bits.
  typedef struct packed {
    logic degenerate;
    logic inside_res;
    logic [CntOutW-1:0] crossings;
  } hit_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [FocW-1:0] cfg_data_i = '0;

  // Predictor state.
  logic [FocW-1:0] focal, ctr_x, ctr_y;
  int unsigned crossing_cnt;
  bit degen_seen;
  hit_result_t pending_counts[$];
  int mismatches = 0;
  bit steady_flow = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  projected_polygon_point_test #(.MAX_EDGES(MaxEdges)) DUT (.*);

  function automatic longint project_coord(longint v, longint z, logic [FocW-1:0] ctr);
    longint f, num, den, q;
    f = longint'(focal);
    num = v * f * 256;
    den = z + f * 256;
    if (den == 0) begin
      degen_seen = 1'b1;
      q = (num > 0) ? SatMag : ((num < 0) ? -SatMag : 0);
    end else begin
      q = num / den;
    end
    return q + longint'(ctr) * 256;
  endfunction

  // Updates the crossing count for one edge; pushes a result on the last one.
  function automatic void predict_crossing(poly_edge_t e);
    longint x1, y1, x2, y2, tx, ty;
    logic signed [127:0] dxt, dyt, dx, dy, lhs, rhs;
    bit hit;
    tx = longint'(e.tx);
    ty = longint'(e.ty);
    x1 = project_coord(longint'(e.sx), longint'(e.sz), ctr_x);
    y1 = project_coord(longint'(e.sy), longint'(e.sz), ctr_y);
    x2 = project_coord(longint'(e.ex), longint'(e.ez), ctr_x);
    y2 = project_coord(longint'(e.ey), longint'(e.ez), ctr_y);
    if ((ty < y1) != (ty < y2)) begin
      dxt = 128'(tx - x1);
      dyt = 128'(ty - y1);
      dx = 128'(x2 - x1);
      dy = 128'(y2 - y1);
      lhs = dxt * dy;
      rhs = dyt * dx;
      hit = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
      if (hit && crossing_cnt < MaxEdges) crossing_cnt++;
    end
    if (e.last) begin
      pending_counts.push_back('{crossings: crossing_cnt[CntOutW-1:0],
                                 inside_res: crossing_cnt[0], degenerate: degen_seen});
      crossing_cnt = 0;
      degen_seen = 1'b0;
    end
  endfunction

  function automatic int rnd_signed(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic int idle_gap();
    return steady_flow ? 0 : int'($urandom_range(0, 7));
  endfunction

  task automatic send_edge(poly_edge_t e);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {e.ez, e.ey, e.ex, e.sz, e.sy, e.sx, e.ty, e.tx};
    s_axis_tlast <= e.last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_crossing(e);
  endtask

  // Drops valid after the last word of a burst and lets the block drain.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [FocW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegFocal:   focal = val;
      RegCenterX: ctr_x = val;
      RegCenterY: ctr_y = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, then the word is checked against the oldest count.
  initial begin
    int gap;
    hit_result_t want, got;
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got = m_axis_tdata[12:0];
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_counts.pop_front();
        if (got !== want || m_axis_tdata[OutW-1:13] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: crossings %0d/%0d inside %b/%b degenerate %b/%b",
                     want.crossings, got.crossings, want.inside_res, got.inside_res,
                     want.degenerate, got.degenerate);
        end
      end
    end
  end

  function automatic poly_edge_t vertical_crossing(logic last);
    poly_edge_t e;
    e.sx = '0; e.sy = -24'sd256; e.sz = '0;
    e.ex = '0; e.ey = 24'sd256; e.ez = '0;
    e.tx = 24'(int'(ctr_x) * 256 - 100);
    e.ty = 24'(int'(ctr_y) * 256);
    e.last = last;
    return e;
  endfunction

  function automatic poly_edge_t noise_edge();
    poly_edge_t e;
    e.tx = 24'($urandom()); e.ty = 24'($urandom());
    e.sx = 24'($urandom()); e.sy = 24'($urandom()); e.sz = 24'($urandom());
    e.ex = 24'($urandom()); e.ey = 24'($urandom()); e.ez = 24'($urandom());
    e.last = ($urandom_range(0, 7) == 0);
    return e;
  endfunction

  task automatic test_extremes();
    poly_edge_t e;
    e = vertical_crossing(1'b0);
    send_edge(e);
    e.ex = 24'sh7FFFFF; e.ey = 24'sh7FFFFF; e.ez = 24'sh7FFFFF;
    e.sx = 24'sh800000; e.sy = 24'sh800000; e.sz = 24'sh800000;
    send_edge(e);
    e.tx = 24'sh7FFFFF; e.ty = 24'sh800000;
    send_edge(e);
    e.tx = 24'sh800000; e.ty = 24'sh7FFFFF; e.last = 1'b1;
    send_edge(e);
    e = vertical_crossing(1'b1);
    e.ey = -24'sd256; e.sy = 24'sd256;  // falling edge, flipped comparison
    send_edge(e);
    e.tx = 24'(int'(ctr_x) * 256 + 100);  // test point right of the edge
    send_edge(e);
    drain_results();
  endtask

  task automatic test_zero_denominator();
    poly_edge_t e;
    e = vertical_crossing(1'b0);
    e.sz = -24'sd7680;  // z cancels F*256 at F = 30
    send_edge(e);
    e.sx = -24'sd5; e.sy = '0;
    send_edge(e);
    e.last = 1'b1;
    send_edge(e);
    drain_results();
    write_reg(RegFocal, '0);
    e = vertical_crossing(1'b1);
    send_edge(e);
    e.ez = 24'sd77;
    send_edge(e);
    drain_results();
    write_reg(RegFocal, 16'hFFFF);
    write_reg(RegCenterX, 16'hFFFF);
    write_reg(RegCenterY, '0);
    write_reg(RegUnused, 16'h1234);
    send_edge(vertical_crossing(1'b1));
    e = vertical_crossing(1'b1);
    e.sz = 24'sh800000; e.ez = 24'sh7FFFFF;
    send_edge(e);
    drain_results();
    write_reg(RegFocal, FocalReset);
    write_reg(RegCenterX, CenterXReset);
    write_reg(RegCenterY, CenterYReset);
  endtask

  task automatic test_count_saturation();
    steady_flow = 1'b1;
    for (int i = 0; i < MaxEdges + 6; i++) send_edge(vertical_crossing(1'b0));
    steady_flow = 1'b0;
    send_edge(vertical_crossing(1'b1));
    drain_results();
  endtask

  task automatic test_random_polygons();
    int verts, sent;
    int vx[8], vy[8], vz[8];
    poly_edge_t e;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: write_reg(RegFocal, 16'd30);
        1: write_reg(RegFocal, 16'd1);
        2: write_reg(RegFocal, 16'hFFFF);
        default: write_reg(RegFocal, 16'($urandom_range(1, 2000)));
      endcase
      write_reg(RegCenterX, (phase == 5) ? 16'hFFFF : 16'($urandom_range(0, 400)));
      write_reg(RegCenterY, (phase == 6) ? 16'h0000 : 16'($urandom_range(0, 400)));
      steady_flow = (phase == 3);
      sent = 0;
      while (sent < 12) begin
        if ($urandom_range(0, 6) == 0) begin
          send_edge(noise_edge());
          sent++;
        end else begin
          verts = $urandom_range(3, 8);
          for (int i = 0; i < verts; i++) begin
            vx[i] = rnd_signed(40000);
            vy[i] = rnd_signed(40000);
            vz[i] = int'($urandom_range(0, 30000)) - 3000;
          end
          e.tx = 24'(int'(ctr_x) * 256 + rnd_signed(30000));
          e.ty = 24'(int'(ctr_y) * 256 + rnd_signed(30000));
          for (int i = 0; i < verts; i++) begin
            e.sx = 24'(vx[i]); e.sy = 24'(vy[i]); e.sz = 24'(vz[i]);
            e.ex = 24'(vx[(i + 1) % verts]); e.ey = 24'(vy[(i + 1) % verts]);
            e.ez = 24'(vz[(i + 1) % verts]);
            e.last = (i == verts - 1);
            send_edge(e);
          end
          sent += verts;
        end
      end
      e = vertical_crossing(1'b1);
      send_edge(e);
      drain_results();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    focal = FocalReset;
    ctr_x = CenterXReset;
    ctr_y = CenterYReset;
    crossing_cnt = 0;
    degen_seen = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_extremes();
    test_zero_denominator();
    test_count_saturation();
    test_random_polygons();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
